// ===== hw/rtl/gdd_pkg.sv =====
// gdd_pkg: shared widths, constants and calendar tables for the gregorian day difference core
// no dependencies; imported by gdd_mul and gregorian_day_difference_core
`default_nettype none

package gdd_pkg;

    // beat field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DIFF_W   = 23;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // shared multiplier operand widths
    localparam int MUL_A_W = 14;
    localparam int MUL_B_W = 13;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // floor(p / 100) = (p * 5243) >> 19, exact for any 14-bit p
    localparam logic [MUL_B_W-1:0] RECIP_100   = 13'd5243;
    localparam int                 RECIP_SHIFT = 19;
    localparam int                 Q100_W      = 8;

    localparam logic [MUL_B_W-1:0] CENTURY     = 13'd100;
    localparam logic [MUL_B_W-1:0] YEAR_DAYS   = 13'd365;
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
    localparam logic [YEAR_W-1:0]  CENT_LAST   = 14'd99;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

    // serial day numbers, day 1 is the first of january of year 1
    localparam int SER_W = 22;
    localparam int DBM_W = 9;

    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic            leap);
        logic [DAY_W-1:0] v;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
            4'd2:    v = leap ? 5'd29 : 5'd28;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gregorian_day_difference_core.sv =====
// gregorian_day_difference_core: signed day count between two gregorian dates
// depends on gdd_pkg and gdd_mul (shared multiplier)
`default_nettype none

// One input beat carries two dates and the include-last-day flag; one output
// beat returns the signed day count and an invalid-date flag. Each date is
// turned into a serial day number by a small sequencer that runs the single
// shared multiplier three times ((year-1)/100 by reciprocal, remainder check
// for the leap rule, 365 times (year-1)), stepping through S_QUO, S_REM,
// S_LEAP and S_SER for each date. The result is registered in S_DIFF once
// both dates are done, and the core is ready again the cycle after, so no
// new beat is taken while one is in flight. The result sits in an output
// register, and the next beat is accepted while it waits; if that beat
// reaches the difference step while the earlier result is still held, the
// core waits there until the result is taken. If either date has a year
// outside 1..9999, a month outside 1..12 or an impossible day, invalid_date
// is 1 and the count is 0. Equal dates give 0, or -1 with include_last_day set.

module gregorian_day_difference_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // first_year, first_month, first_day, second_year, second_month,
    // second_day, include_last_day, zero pad
    input  wire logic [gdd_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // day_difference, invalid_date
    output logic      [gdd_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    import gdd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUO,
        S_REM,
        S_LEAP,
        S_SER,
        S_DIFF
    } t_state;

    t_state r_state;

    logic [YEAR_W-1:0]  r_y1, r_y2;
    logic [MONTH_W-1:0] r_m1, r_m2;
    logic [DAY_W-1:0]   r_d1, r_d2;
    logic               r_inc;
    logic               r_sel;
    logic               r_bad;
    logic               r_leap;
    logic [Q100_W-1:0]  r_q100;
    logic [SER_W-1:0]   r_s1, r_s2;
    logic               r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;

    logic [YEAR_W-1:0]  y_cur, p_cur, r100;
    logic [MONTH_W-1:0] m_cur;
    logic [DAY_W-1:0]   d_cur, len_cur;
    logic               leap_now, date_ok, feb_adj;
    logic [SER_W-1:0]   n_ser;
    logic [DIFF_W-1:0]  diff, n_result;
    logic               diff_pos;
    logic               res_load;

    gdd_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign y_cur = r_sel ? r_y2 : r_y1;
    assign m_cur = r_sel ? r_m2 : r_m1;
    assign d_cur = r_sel ? r_d2 : r_d1;
    assign p_cur = y_cur - YEAR_W'(1);

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_QUO: begin
                mul_a = p_cur;
                mul_b = RECIP_100;
            end
            S_REM: begin
                mul_a = MUL_A_W'(prod[RECIP_SHIFT +: Q100_W]);
                mul_b = CENTURY;
            end
            default: begin
                mul_a = p_cur;
                mul_b = YEAR_DAYS;
            end
        endcase
    end

    // y % 100 == 0 when p % 100 == 99; y % 400 == 0 when also (p/100) % 4 == 3
    assign r100     = p_cur - prod[YEAR_W-1:0];
    assign leap_now = (y_cur[1:0] == 2'd0) &&
                      ((r100 != CENT_LAST) || (r_q100[1:0] == 2'd3));

    assign len_cur = month_length(m_cur, r_leap);
    assign date_ok = (y_cur != '0) && (y_cur <= YEAR_MAX) &&
                     (m_cur != '0) && (m_cur <= MONTH_DEC) &&
                     (d_cur != '0) && (d_cur <= len_cur);
    assign feb_adj = (m_cur > MONTH_FEB) && r_leap;

    assign n_ser = prod[SER_W-1:0]
                 + SER_W'(p_cur[YEAR_W-1:2])
                 - SER_W'(r_q100)
                 + SER_W'(r_q100[Q100_W-1:2])
                 + SER_W'(days_before_month(m_cur))
                 + SER_W'(feb_adj)
                 + SER_W'(d_cur);

    // negative result is -(s1 - s2 + inc) = diff - inc
    assign diff     = {1'b0, r_s2} - {1'b0, r_s1};
    assign diff_pos = !diff[DIFF_W-1] && (diff != '0);
    assign n_result = diff_pos ? diff + DIFF_W'(r_inc) : diff - DIFF_W'(r_inc);

    // output register is free or being emptied this cycle
    assign res_load = (r_state == S_DIFF) && (!r_m_tvalid || i_m_tready);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
            r_sel      <= 1'b0;
            r_bad      <= 1'b0;
        end else begin
            if (res_load) begin
                r_m_tvalid <= 1'b1;
            end else if (r_m_tvalid && i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_y1    <= i_s_tdata[13:0];
                        r_m1    <= i_s_tdata[17:14];
                        r_d1    <= i_s_tdata[22:18];
                        r_y2    <= i_s_tdata[36:23];
                        r_m2    <= i_s_tdata[40:37];
                        r_d2    <= i_s_tdata[45:41];
                        r_inc   <= i_s_tdata[46];
                        r_sel   <= 1'b0;
                        r_bad   <= 1'b0;
                        r_state <= S_QUO;
                    end
                end
                S_QUO: begin
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_q100  <= prod[RECIP_SHIFT +: Q100_W];
                    r_state <= S_LEAP;
                end
                S_LEAP: begin
                    r_leap  <= leap_now;
                    r_state <= S_SER;
                end
                S_SER: begin
                    r_bad <= r_bad || !date_ok;
                    if (r_sel) begin
                        r_s2    <= n_ser;
                        r_state <= S_DIFF;
                    end else begin
                        r_s1    <= n_ser;
                        r_sel   <= 1'b1;
                        r_state <= S_QUO;
                    end
                end
                S_DIFF: begin
                    if (res_load) begin
                        r_m_tdata  <= r_bad ? {1'b1, {DIFF_W{1'b0}}} : {1'b0, n_result};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gdd_mul.sv =====
// gdd_mul: shared unsigned multiplier with a registered product
// depends on gdd_pkg for default operand widths
`default_nettype none

module gdd_mul #(
    parameter int A_W = gdd_pkg::MUL_A_W,
    parameter int B_W = gdd_pkg::MUL_B_W
) (
    input  wire logic               i_clk,
    input  wire logic [A_W-1:0]     i_a,
    input  wire logic [B_W-1:0]     i_b,
    output logic      [A_W+B_W-1:0] o_prod
);

    always_ff @(posedge i_clk) begin
        o_prod <= {{B_W{1'b0}}, i_a} * {{A_W{1'b0}}, i_b};
    end

endmodule

`default_nettype wire
